FILE: rtl/rsa_pkg.sv
// Shared constants, register indexes and controller-datapath types for RSA exponentiation.
package rsa_pkg;

   localparam int FIELD_BITS        = 32;
   localparam int WORD_BITS_DEFAULT = 32;
   localparam int CSR_INDEX_BITS    = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPONENT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS  = 2'd1;

   localparam logic [FIELD_BITS-1:0] EXPONENT_RESET = 32'd3;
   localparam logic [FIELD_BITS-1:0] MODULUS_RESET  = 32'd15;

   typedef enum logic [2:0] {
      OP_HOLD   = 3'd0,
      OP_LOAD   = 3'd1,
      OP_REDUCE = 3'd2,
      OP_SQUARE = 3'd3,
      OP_MULT   = 3'd4,
      OP_OUTPUT = 3'd5
   } op_type;

   typedef struct packed {
      op_type op;
      logic   exp_next;
   } cmd_type;

   typedef struct packed {
      logic bit_last;
      logic exp_last;
      logic exp_bit;
   } status_type;

endpackage

FILE: rtl/rsa_req_if.sv
// Input channel carrying one message word per handshake.
interface rsa_req_if;
   logic                           valid;
   logic                           ready;
   logic [rsa_pkg::FIELD_BITS-1:0] message_value;

   modport source (output valid, output message_value, input ready);
   modport sink (input valid, input message_value, output ready);
endinterface

FILE: rtl/rsa_rsp_if.sv
// Result channel carrying one exponentiation result word per handshake.
interface rsa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rsa_pkg::FIELD_BITS-1:0] result_value;

   modport source (output valid, output result_value, input ready);
   modport sink (input valid, input result_value, output ready);
endinterface

FILE: rtl/rsa_csr_if.sv
// Configuration write channel carrying a register index and write data.
interface rsa_csr_if;
   logic                               valid;
   logic                               ready;
   logic [rsa_pkg::CSR_INDEX_BITS-1:0] index;
   logic [rsa_pkg::FIELD_BITS-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/rsa_dp.sv
// Datapath: key registers, input reduction and bit-serial modular multiplier.
module rsa_dp #(
   parameter int WORD_BITS = rsa_pkg::WORD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [rsa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rsa_pkg::FIELD_BITS-1:0]     csr_data,
   input  logic [rsa_pkg::FIELD_BITS-1:0]     message_value,
   input  rsa_pkg::cmd_type                   cmd,
   output rsa_pkg::status_type                status,
   output logic [rsa_pkg::FIELD_BITS-1:0]     result_value
);

   localparam int FieldBits = rsa_pkg::FIELD_BITS;
   localparam int IdxBits   = $clog2(WORD_BITS);
   localparam logic [IdxBits-1:0] LastIdx = IdxBits'(WORD_BITS - 1);

   logic [FieldBits-1:0] exponent_ff, exponent_in;
   logic [FieldBits-1:0] modulus_ff, modulus_in;
   logic [WORD_BITS-1:0] exponent_w, modulus_w;

   logic [WORD_BITS-1:0] xs_ff, xs_in;
   logic [WORD_BITS-1:0] base_ff, base_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] r_ff, r_in;
   logic [FieldBits-1:0] result_ff, result_in;
   logic [IdxBits-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [IdxBits-1:0]   exp_cnt_ff, exp_cnt_in;

   logic [WORD_BITS:0]   rem_t;
   logic [WORD_BITS-1:0] rem_next;
   logic [WORD_BITS-1:0] acc_src, addend, acc_next;
   logic [WORD_BITS+1:0] mul_t, mod1, mod2;
   logic                 b_bit;
   logic [IdxBits-1:0]   bit_cnt_dec;

   assign exponent_w = WORD_BITS'(exponent_ff);
   assign modulus_w  = WORD_BITS'(modulus_ff);

   assign bit_cnt_dec = (bit_cnt_ff == '0) ? LastIdx : bit_cnt_ff - 1'b1;

   assign status.bit_last = (bit_cnt_ff == '0);
   assign status.exp_last = (exp_cnt_ff == '0);
   assign status.exp_bit  = exponent_w[exp_cnt_ff];

   // One restoring remainder step: shift in the next message bit, subtract once.
   always_comb begin
      rem_t    = {base_ff, xs_ff[WORD_BITS-1]};
      rem_next = (rem_t >= {1'b0, modulus_w}) ? WORD_BITS'(rem_t - {1'b0, modulus_w})
                                              : WORD_BITS'(rem_t);
   end

   // One double-and-add step; the sum stays below three times the modulus.
   always_comb begin
      acc_src  = (bit_cnt_ff == LastIdx) ? '0 : acc_ff;
      b_bit    = (cmd.op == rsa_pkg::OP_MULT) ? base_ff[bit_cnt_ff] : r_ff[bit_cnt_ff];
      addend   = b_bit ? r_ff : '0;
      mod1     = {2'b00, modulus_w};
      mod2     = {1'b0, modulus_w, 1'b0};
      mul_t    = {1'b0, acc_src, 1'b0} + {2'b00, addend};
      if (mul_t >= mod2) begin
         acc_next = WORD_BITS'(mul_t - mod2);
      end else if (mul_t >= mod1) begin
         acc_next = WORD_BITS'(mul_t - mod1);
      end else begin
         acc_next = WORD_BITS'(mul_t);
      end
   end

   always_comb begin
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      if (csr_write) begin
         unique case (csr_index)
            rsa_pkg::CSR_EXPONENT: exponent_in = csr_data;
            rsa_pkg::CSR_MODULUS:  modulus_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      xs_in      = xs_ff;
      base_in    = base_ff;
      acc_in     = acc_ff;
      r_in       = r_ff;
      result_in  = result_ff;
      bit_cnt_in = bit_cnt_ff;
      exp_cnt_in = exp_cnt_ff;
      unique case (cmd.op)
         rsa_pkg::OP_LOAD: begin
            xs_in      = WORD_BITS'(message_value);
            base_in    = '0;
            r_in       = (modulus_w == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
            bit_cnt_in = LastIdx;
            exp_cnt_in = LastIdx;
         end
         rsa_pkg::OP_REDUCE: begin
            xs_in      = {xs_ff[WORD_BITS-2:0], 1'b0};
            base_in    = rem_next;
            bit_cnt_in = bit_cnt_dec;
         end
         rsa_pkg::OP_SQUARE, rsa_pkg::OP_MULT: begin
            acc_in     = acc_next;
            bit_cnt_in = bit_cnt_dec;
            if (bit_cnt_ff == '0) begin
               r_in = acc_next;
            end
         end
         rsa_pkg::OP_OUTPUT: begin
            result_in = (modulus_w == '0) ? '0 : FieldBits'(r_ff);
         end
         default: begin
         end
      endcase
      if (cmd.exp_next) begin
         exp_cnt_in = exp_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= rsa_pkg::EXPONENT_RESET;
         modulus_ff  <= rsa_pkg::MODULUS_RESET;
      end else begin
         exponent_ff <= exponent_in;
         modulus_ff  <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff      <= xs_in;
      base_ff    <= base_in;
      acc_ff     <= acc_in;
      r_ff       <= r_in;
      result_ff  <= result_in;
      bit_cnt_ff <= bit_cnt_in;
      exp_cnt_ff <= exp_cnt_in;
   end

   assign result_value = result_ff;

   a_base_reduced: assert property (@(posedge clock) disable iff (reset)
      cmd.op == rsa_pkg::OP_REDUCE && modulus_w != '0 |=> base_ff < modulus_w)
      else $error("reduced message not below modulus");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == rsa_pkg::OP_SQUARE || cmd.op == rsa_pkg::OP_MULT) && modulus_w != '0
      |=> acc_ff < modulus_w)
      else $error("modular product not below modulus");

endmodule

FILE: rtl/rsa_ctrl.sv
// Controller: sequences reduction, square and multiply passes, and owns the result handshake.
module rsa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rsa_pkg::status_type status,
   output rsa_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_REDUCE = 5'b00010,
      S_SQUARE = 5'b00100,
      S_MULT   = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = rsa_pkg::OP_HOLD;
      cmd.exp_next = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = rsa_pkg::OP_LOAD;
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            cmd.op = rsa_pkg::OP_REDUCE;
            if (status.bit_last) begin
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.op = rsa_pkg::OP_SQUARE;
            if (status.bit_last) begin
               if (status.exp_bit) begin
                  state_in = S_MULT;
               end else if (status.exp_last) begin
                  state_in = S_DONE;
               end else begin
                  cmd.exp_next = 1'b1;
               end
            end
         end
         S_MULT: begin
            cmd.op = rsa_pkg::OP_MULT;
            if (status.bit_last) begin
               if (status.exp_last) begin
                  state_in = S_DONE;
               end else begin
                  cmd.exp_next = 1'b1;
                  state_in     = S_SQUARE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = rsa_pkg::OP_OUTPUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_REDUCE)
      else $error("accepted word did not start reduction");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the finish state");

   a_done_drains: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && !rsp_valid_ff |=> state_ff == S_IDLE && rsp_valid_ff)
      else $error("finished result not moved to the output register");

endmodule

FILE: rtl/rsa_modular_exponentiation.sv
// Top level of the RSA modular exponentiation block.
//
// Each word accepted on req_chan (valid and ready high at a rising clock edge)
// returns one word on rsp_chan: message_value raised to the exponent register,
// reduced modulo the modulus register. A modulus of zero gives zero.
// Registers are written on csr_chan: index 0 is the exponent, index 1 the
// modulus; other indexes are ignored. The channel is always ready, and writes
// belong only to times when no word is in flight.
// The message is reduced first, then for each of the WORD_BITS exponent bits
// there is one modular square, plus one multiply for every set bit, and then
// the result is loaded into the output register. The next word can be
// accepted at the edge of the earliest result handshake. The shared
// bit-serial modular multiplier sets the rate.
// One word is worked on at a time; req_chan is ready only between words.
// A result waits in the output register while the receiver stalls, and the
// next word is taken meanwhile; it finishes but waits until that register frees.
// Reset (synchronous, active high) empties the block and restores exponent 3
// and modulus 15.
module rsa_modular_exponentiation #(
   parameter int WORD_BITS = rsa_pkg::WORD_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   rsa_req_if.sink    req_chan,
   rsa_rsp_if.source  rsp_chan,
   rsa_csr_if.sink    csr_chan
);

   rsa_pkg::cmd_type    cmd;
   rsa_pkg::status_type status;

   assign csr_chan.ready = 1'b1;

   rsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rsa_dp #(
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_chan.valid),
      .csr_index     (csr_chan.index),
      .csr_data      (csr_chan.data),
      .message_value (req_chan.message_value),
      .cmd           (cmd),
      .status        (status),
      .result_value  (rsp_chan.result_value)
   );

endmodule

FILE: verif/tb_top.sv
// Self-checking regression for the RSA modular exponentiation block.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [rsa_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [rsa_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_3 = 2'd3;
   localparam int MAX_LATENCY = 2200;
   localparam int HOLD_CYCLES = 6000;
   localparam int CYCLE_LIMIT = 3_000_000;

   typedef logic [rsa_pkg::FIELD_BITS-1:0] word_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     hold_rsp = 1'b0;
   int       rsp_stall_pct = 0;
   int       send_idle_pct = 0;
   int       errors = 0;
   int       cycle_count = 0;
   word_type exponent_reg = rsa_pkg::EXPONENT_RESET;
   word_type modulus_reg = rsa_pkg::MODULUS_RESET;
   word_type expected_results[$];

   rsa_req_if req_bus ();
   rsa_rsp_if rsp_bus ();
   rsa_csr_if csr_bus ();

   rsa_modular_exponentiation dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #1 clock = ~clock;

   // Square-and-multiply over all exponent bits; products of two residues fit in 64 bits.
   function automatic word_type power_mod(input word_type base_in, input word_type exp_in,
                                          input word_type mod_in);
      logic [63:0] m;
      logic [63:0] base;
      logic [63:0] acc;
      int          i;
      if (mod_in == '0) begin
         return '0;
      end
      m = mod_in;
      base = base_in % m;
      acc = 64'd1 % m;
      for (i = rsa_pkg::FIELD_BITS - 1; i >= 0; i--) begin
         acc = (acc * acc) % m;
         if (exp_in[i]) begin
            acc = (acc * base) % m;
         end
      end
      return acc[rsa_pkg::FIELD_BITS-1:0];
   endfunction

   function automatic word_type pick_message();
      case ($urandom_range(9))
         0, 1: return $urandom_range(255, 0);
         2: return modulus_reg - 1;
         3: return modulus_reg;
         4: return modulus_reg + $urandom_range(3, 1);
         5, 6: return (modulus_reg == '0) ? $urandom() : $urandom() % modulus_reg;
         default: return $urandom();
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_bus.ready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h",
                     $time, rsp_bus.result_value);
            errors++;
         end else begin
            if (expected_results[0] !== rsp_bus.result_value) begin
               $display("%0t: result mismatch, expected %h, actual %h",
                        $time, expected_results[0], rsp_bus.result_value);
               errors++;
            end
            void'(expected_results.pop_front());
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rsa_modular_exponentiation regression: fail");
      $finish;
   end

   task automatic send_message(input word_type value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(MAX_LATENCY, 1)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.message_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.insert(expected_results.size(),
                              power_mod(value, exponent_reg, modulus_reg));
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [rsa_pkg::CSR_INDEX_BITS-1:0] index,
                                 input word_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (index)
         rsa_pkg::CSR_EXPONENT: exponent_reg = value;
         rsa_pkg::CSR_MODULUS: modulus_reg = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_keys(input word_type exp_value, input word_type mod_value);
      wait_idle();
      write_register(rsa_pkg::CSR_EXPONENT, exp_value);
      write_register(rsa_pkg::CSR_MODULUS, mod_value);
   endtask

   task automatic choose_keys();
      word_type exp_value;
      word_type mod_value;
      case ($urandom_range(9))
         0: exp_value = '0;
         1: exp_value = 32'd1;
         2: exp_value = '1;
         3, 4: exp_value = $urandom_range(65537, 2);
         default: exp_value = $urandom();
      endcase
      case ($urandom_range(19))
         0: mod_value = $urandom_range(1, 0);
         1, 2: mod_value = '1;
         3, 4, 5, 6: mod_value = $urandom_range(300, 2);
         7, 8, 9, 10: mod_value = $urandom() | 32'h8000_0000;
         default: mod_value = $urandom();
      endcase
      set_keys(exp_value, mod_value);
      if ($urandom_range(9) == 0) begin
         write_register($urandom_range(1, 0) ? CSR_SPARE_2 : CSR_SPARE_3, $urandom());
      end
   endtask

   task automatic test_reset_values();
      send_message(32'd0);
      send_message(32'd1);
      send_message(32'd2);
      send_message(32'd14);
      send_message(32'd15);
      send_message(32'd16);
      send_message('1);
   endtask

   task automatic test_extremes();
      set_keys('1, '1);
      send_message(32'd0);
      send_message(32'd1);
      send_message(32'hFFFF_FFFE);
      send_message('1);
      set_keys('1, 32'd2);
      send_message(32'h8000_0001);
      set_keys(32'd1, '1);
      send_message(32'hDEAD_BEEF);
   endtask

   task automatic test_special_cases();
      set_keys('0, 32'd2);
      send_message(32'd0);
      send_message('1);
      set_keys(32'd5, 32'd1);
      send_message(32'd12345);
      set_keys(32'd5, '0);
      send_message(32'd99);
      set_keys(32'd7, 32'd1000003);
      write_register(CSR_SPARE_2, '0);
      write_register(CSR_SPARE_3, '1);
      send_message(32'd2000007);
      send_message(32'd1000003);
   endtask

   task automatic test_rsa_key_pair();
      set_keys(32'd17, 32'd3233);
      send_message(32'd65);
      set_keys(32'd2753, 32'd3233);
      send_message(32'd2790);
      send_message(32'd65);
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int stall_pct);
      int i;
      wait_idle();
      send_idle_pct = send_pct;
      rsp_stall_pct <= stall_pct;
      for (i = 0; i < count; i++) begin
         if (i % 15 == 0) begin
            choose_keys();
         end else if ($urandom_range(99) < 3) begin
            wait_idle();
         end
         send_message(pick_message());
      end
      wait_idle();
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
   endtask

   // The receiver holds off long enough for a finished word to sit in the output
   // register and the next one to stall behind it.
   task automatic test_output_backpressure();
      int i;
      set_keys($urandom(), $urandom() | 32'h8000_0000);
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      for (i = 0; i < 10; i++) begin
         if (i == 5) begin
            wait_idle();
         end
         send_message(pick_message());
      end
      wait_idle();
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.message_value = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_extremes();
      test_special_cases();
      test_rsa_key_pair();
      test_random_traffic(60, 0, 0);
      test_random_traffic(60, 57, 0);
      test_random_traffic(60, 0, 57);
      test_random_traffic(60, 12, 12);
      test_output_backpressure();
      wait_idle();
      repeat (MAX_LATENCY) @(posedge clock);
      if (errors == 0) begin
         $display("rsa_modular_exponentiation regression: pass");
      end else begin
         $display("rsa_modular_exponentiation regression: fail");
      end
      $finish;
   end

endmodule
